/* rtl/core/braking_episode_coefficient_unit_defines.svh */
// Assertion macros shared by the braking episode coefficient RTL
`ifndef BRAKING_EPISODE_COEFFICIENT_UNIT_DEFINES_SVH
`define BRAKING_EPISODE_COEFFICIENT_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BECU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BECU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/becu_pkg.sv */
// Types, widths and codes for the braking episode coefficient unit
`default_nettype none
package becu_pkg;
   localparam int unsigned MAX_SAMPLES = 1000;
   localparam int unsigned SAMPLE_W    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned PRESS_W     = 12;
   localparam int unsigned SPEED_W     = 16;
   localparam int unsigned DT_W        = 24;
   localparam int unsigned COEF_W      = 48;
   localparam int unsigned SUM_W       = 52;
   localparam int unsigned PSUM_W      = 22;
   localparam int unsigned ACCEL_STEPS = SPEED_W + DT_W;
   localparam int unsigned ACC_W       = ACCEL_STEPS + 1;
   localparam int unsigned NUM_W       = 64;
   localparam int unsigned MAG_W       = NUM_W - 1;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned DEN_W       = PSUM_W + SAMPLE_W;
   localparam int unsigned DVD_W       = MAG_W + FRAC_W;
   localparam int unsigned COEF_STEPS  = DVD_W;
   localparam int unsigned DIV_STEP_W  = $clog2(DVD_W + 1);
   localparam int unsigned MUL_STEPS   = 2 * SAMPLE_W;
   localparam int unsigned MUL_STEP_W  = $clog2(MUL_STEPS);
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_SPEED         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BRAKED         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_LOW         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_HIGH        = 3'd4;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED   = 3'd0,
      STATUS_OUTSIDE    = 3'd1,
      STATUS_BRAKED_ST  = 3'd2,
      STATUS_TOO_SHORT  = 3'd3,
      STATUS_NO_BRAKING = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_ACCEL, ST_UPDATE, ST_MUL,
      ST_CDIV, ST_CWAIT, ST_FINISH, ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic busy;
   } div_rsp_type;
endpackage
`default_nettype wire

/* rtl/core/becu_divider.sv */
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module becu_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  becu_pkg::div_req_type         div_req,
   input  logic [becu_pkg::DVD_W-1:0]    dividend,
   input  logic [becu_pkg::DEN_W-1:0]    divisor,
   output becu_pkg::div_rsp_type         div_rsp,
   output logic [becu_pkg::DVD_W-1:0]    quotient
);
   import becu_pkg::*;

   logic                  run_ff, run_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [DVD_W-1:0]      quo_ff, quo_in;
   logic [DEN_W:0]        partial;
   logic [DEN_W:0]        diff;

   always_comb begin
      partial = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = partial - {1'b0, den_ff};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = div_req.steps;
         rem_in = '0;
         den_in = divisor;
         dvd_in = dividend;
         quo_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], ~diff[DEN_W]};
         rem_in = diff[DEN_W] ? partial[DEN_W-1:0] : diff[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         run_in = (cnt_ff != DIV_STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy = run_ff;
   assign quotient     = quo_ff;
endmodule
`default_nettype wire

/* rtl/core/braking_episode_coefficient_unit.sv */
// A sample that ends nothing runs a 40-step acceleration divide, except the first sample
// of an episode, which skips it. An episode end adds a shift-add multiply and a 79-step
// coefficient divide before the result beat; one shared serial divider serves both divides.
// One sample at a time: req_stall stays high until the sample is done or its result beat leaves.
// Synchronous reset loads the register defaults and clears the episode.
`default_nettype none
`include "braking_episode_coefficient_unit_defines.svh"
module braking_episode_coefficient_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [becu_pkg::PRESS_W-1:0]      req_pressure,
   input  logic [becu_pkg::SPEED_W-1:0]      req_speed,
   input  logic [becu_pkg::DT_W-1:0]         req_interval_us,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic signed [becu_pkg::COEF_W-1:0] rsp_coefficient,
   output logic [becu_pkg::SAMPLE_W-1:0]     rsp_braked_samples,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [becu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [becu_pkg::COEF_W-1:0]       csr_data
);
   import becu_pkg::*;

   state_type state_ff, state_in;

   logic [PRESS_W-1:0]       thr_ff, thr_in;
   logic [SPEED_W-1:0]       stop_ff, stop_in;
   logic [SAMPLE_W-1:0]      minb_ff, minb_in;
   logic signed [COEF_W-1:0] low_ff, low_in;
   logic signed [COEF_W-1:0] high_ff, high_in;

   logic [PRESS_W-1:0]       p_ff, p_in;
   logic [SPEED_W-1:0]       v_ff, v_in;
   logic [DT_W-1:0]          dt_ff, dt_in;

   logic [SAMPLE_W-1:0]      si_ff, si_in;
   logic [SAMPLE_W-1:0]      bc_ff, bc_in;
   logic [SAMPLE_W-1:0]      fc_ff, fc_in;
   logic [SPEED_W-1:0]       prev_ff, prev_in;
   logic signed [SUM_W-1:0]  fsum_ff, fsum_in;
   logic signed [SUM_W-1:0]  bsum_ff, bsum_in;
   logic [PSUM_W-1:0]        psum_ff, psum_in;

   logic signed [ACC_W-1:0]  accel_ff, accel_in;
   logic                     dvneg_ff, dvneg_in;
   logic                     compute_ff, compute_in;
   status_type               status_ff, status_in;
   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic signed [NUM_W-1:0]  acc_ff, acc_in;
   logic signed [NUM_W-1:0]  mula_ff, mula_in;
   logic [SAMPLE_W-1:0]      muln_ff, muln_in;
   logic [MUL_STEP_W-1:0]    step_ff, step_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     nneg_ff, nneg_in;

   logic [2:0]               ost_ff, ost_in;
   logic signed [COEF_W-1:0] ocoef_ff, ocoef_in;
   logic [SAMPLE_W-1:0]      obc_ff, obc_in;

   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic [DVD_W-1:0]         div_dividend;
   logic [DEN_W-1:0]         div_divisor;
   logic [DVD_W-1:0]         div_quotient;

   logic                     braked;
   logic [SPEED_W:0]         dv;
   logic [SPEED_W-1:0]       dv_mag;
   logic [DT_W-1:0]          dt_safe;
   logic [ACCEL_STEPS-1:0]   q_accel;
   logic [SAMPLE_W-1:0]      bc_new;
   logic [SAMPLE_W-1:0]      si_new;
   logic signed [NUM_W-1:0]  mul_term;
   logic [NUM_W-1:0]         num_abs;
   logic                     big;

   becu_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_rsp  (div_rsp),
      .quotient (div_quotient)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESPOND);
   assign rsp_status         = ost_ff;
   assign rsp_coefficient    = ocoef_ff;
   assign rsp_braked_samples = obc_ff;
   assign csr_ready          = 1'b1;

   always_comb begin
      thr_in  = thr_ff;
      stop_in = stop_ff;
      minb_in = minb_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESSURE_THRESHOLD: thr_in  = csr_data[PRESS_W-1:0];
            CSR_STOP_SPEED:         stop_in = csr_data[SPEED_W-1:0];
            CSR_MIN_BRAKED:         minb_in = csr_data[SAMPLE_W-1:0];
            CSR_ACCEPT_LOW:         low_in  = csr_data;
            CSR_ACCEPT_HIGH:        high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      braked   = (p_ff > thr_ff);
      dv       = {1'b0, v_ff} - {1'b0, prev_ff};
      dv_mag   = dv[SPEED_W] ? SPEED_W'(-dv) : dv[SPEED_W-1:0];
      dt_safe  = (dt_ff == '0) ? DT_W'(1) : dt_ff;
      q_accel  = div_quotient[ACCEL_STEPS-1:0];
      bc_new   = braked ? bc_ff + 1'b1 : bc_ff;
      si_new   = si_ff + 1'b1;
      mul_term = muln_ff[0] ? mula_ff : '0;
      num_abs  = acc_ff[NUM_W-1] ? -acc_ff : acc_ff;
      big      = |div_quotient[DVD_W-1:COEF_W-1];

      state_in   = state_ff;
      p_in       = p_ff;
      v_in       = v_ff;
      dt_in      = dt_ff;
      si_in      = si_ff;
      bc_in      = bc_ff;
      fc_in      = fc_ff;
      prev_in    = prev_ff;
      fsum_in    = fsum_ff;
      bsum_in    = bsum_ff;
      psum_in    = psum_ff;
      accel_in   = accel_ff;
      dvneg_in   = dvneg_ff;
      compute_in = compute_ff;
      status_in  = status_ff;
      coef_in    = coef_ff;
      acc_in     = acc_ff;
      mula_in    = mula_ff;
      muln_in    = muln_ff;
      step_in    = step_ff;
      den_in     = den_ff;
      nneg_in    = nneg_ff;
      ost_in     = ost_ff;
      ocoef_in   = ocoef_ff;
      obc_in     = obc_ff;
      div_req.start = 1'b0;
      div_req.steps = DIV_STEP_W'(ACCEL_STEPS);
      div_dividend  = {dv_mag, DT_W'(0), (DVD_W-ACCEL_STEPS)'(0)};
      div_divisor   = DEN_W'(dt_safe);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               p_in     = req_pressure;
               v_in     = req_speed;
               dt_in    = req_interval_us;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            dvneg_in = dv[SPEED_W];
            if (si_ff == '0 && braked) begin
               compute_in = 1'b0;
               status_in  = STATUS_BRAKED_ST;
               coef_in    = '0;
               state_in   = ST_FINISH;
            end else if (si_ff != '0) begin
               div_req.start = 1'b1;
               state_in      = ST_ACCEL;
            end else begin
               accel_in = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_ACCEL: begin
            if (!div_rsp.busy) begin
               accel_in = dvneg_ff ? -$signed({1'b0, q_accel}) : $signed({1'b0, q_accel});
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            prev_in = v_ff;
            if (!braked && bc_ff == '0) begin
               fsum_in = fsum_ff + SUM_W'(accel_ff);
               fc_in   = fc_ff + 1'b1;
            end
            if (braked) begin
               psum_in = psum_ff + PSUM_W'(p_ff);
               bsum_in = bsum_ff + SUM_W'(accel_ff);
            end
            bc_in      = bc_new;
            si_in      = si_new;
            compute_in = 1'b0;
            coef_in    = '0;
            acc_in     = '0;
            step_in    = '0;
            mula_in    = NUM_W'(bsum_in);
            muln_in    = fc_in;
            if (braked && bc_new == SAMPLE_W'(MAX_SAMPLES - 1)) begin
               compute_in = 1'b1;
               state_in   = ST_MUL;
            end else if ((!braked || v_ff <= stop_ff) && bc_new != '0) begin
               if (bc_new < minb_ff) begin
                  status_in = STATUS_TOO_SHORT;
                  state_in  = ST_FINISH;
               end else begin
                  compute_in = 1'b1;
                  state_in   = ST_MUL;
               end
            end else if (si_new >= SAMPLE_W'(MAX_SAMPLES)) begin
               if (bc_new != '0) begin
                  compute_in = 1'b1;
                  state_in   = ST_MUL;
               end else begin
                  status_in = STATUS_NO_BRAKING;
                  state_in  = ST_FINISH;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            // numerator Sb*nf - Sf*nb by shift-add
            den_in  = DEN_W'(psum_ff * fc_ff);
            acc_in  = (step_ff >= MUL_STEP_W'(SAMPLE_W)) ? acc_ff - mul_term
                                                         : acc_ff + mul_term;
            step_in = step_ff + 1'b1;
            if (step_ff == MUL_STEP_W'(SAMPLE_W - 1)) begin
               mula_in = NUM_W'(fsum_ff);
               muln_in = bc_ff;
            end else begin
               mula_in = mula_ff <<< 1;
               muln_in = muln_ff >> 1;
            end
            if (step_ff == MUL_STEP_W'(MUL_STEPS - 1)) begin
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            nneg_in = acc_ff[NUM_W-1];
            if (den_ff == '0) begin
               coef_in  = '0;
               state_in = ST_FINISH;
            end else begin
               div_req.start = 1'b1;
               div_req.steps = DIV_STEP_W'(COEF_STEPS);
               div_dividend  = {num_abs[MAG_W-1:0], FRAC_W'(0)};
               div_divisor   = den_ff;
               state_in      = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (!div_rsp.busy) begin
               if (nneg_ff) begin
                  coef_in = big ? {1'b1, (COEF_W-1)'(0)} : -div_quotient[COEF_W-1:0];
               end else begin
                  coef_in = (big || div_quotient[COEF_W-1]) ? {1'b0, {(COEF_W-1){1'b1}}}
                                                            : div_quotient[COEF_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (compute_ff) begin
               ost_in = (coef_ff > low_ff && coef_ff < high_ff) ? STATUS_ACCEPTED
                                                                : STATUS_OUTSIDE;
            end else begin
               ost_in = status_ff;
            end
            ocoef_in = coef_ff;
            obc_in   = bc_ff;
            si_in    = '0;
            bc_in    = '0;
            fc_in    = '0;
            prev_in  = '0;
            fsum_in  = '0;
            bsum_in  = '0;
            psum_in  = '0;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff   <= PRESS_W'(827);
         stop_ff  <= SPEED_W'(256);
         minb_ff  <= SAMPLE_W'(300);
         low_ff   <= -COEF_W'(2814750);
         high_ff  <= -COEF_W'(28147);
         si_ff    <= '0;
         bc_ff    <= '0;
         fc_ff    <= '0;
         prev_ff  <= '0;
         fsum_ff  <= '0;
         bsum_ff  <= '0;
         psum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         thr_ff   <= thr_in;
         stop_ff  <= stop_in;
         minb_ff  <= minb_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         si_ff    <= si_in;
         bc_ff    <= bc_in;
         fc_ff    <= fc_in;
         prev_ff  <= prev_in;
         fsum_ff  <= fsum_in;
         bsum_ff  <= bsum_in;
         psum_ff  <= psum_in;
      end
      p_ff       <= p_in;
      v_ff       <= v_in;
      dt_ff      <= dt_in;
      accel_ff   <= accel_in;
      dvneg_ff   <= dvneg_in;
      compute_ff <= compute_in;
      status_ff  <= status_in;
      coef_ff    <= coef_in;
      acc_ff     <= acc_in;
      mula_ff    <= mula_in;
      muln_ff    <= muln_in;
      step_ff    <= step_in;
      den_ff     <= den_in;
      nneg_ff    <= nneg_in;
      ost_ff     <= ost_in;
      ocoef_ff   <= ocoef_in;
      obc_ff     <= obc_in;
   end

   `BECU_ASSERT_NEXT(a_accept_prep, req_valid && !req_stall, state_ff == ST_PREP, "accepted beat did not start work")
   `BECU_ASSERT_NOW(a_unused_coef, rsp_valid && rsp_status != STATUS_ACCEPTED && rsp_status != STATUS_OUTSIDE, rsp_coefficient == '0, "coefficient set on a status without one")
   `BECU_ASSERT_NOW(a_braked_bound, state_ff == ST_IDLE, bc_ff < SAMPLE_W'(MAX_SAMPLES - 1), "braked count past limit while idle")
   `BECU_ASSERT_NOW(a_div_idle, state_ff == ST_IDLE || state_ff == ST_RESPOND, !div_rsp.busy, "divider busy outside a divide")
endmodule
`default_nettype wire
